>>> rtl/core/cialu_pkg.sv
package cialu_pkg;

   localparam int RES_W      = 33;
   localparam int OUT_DATA_W = 72;

   typedef logic [1:0] action_type;

   localparam action_type ACT_ADD = 2'd0;
   localparam action_type ACT_SUB = 2'd1;
   localparam action_type ACT_MUL = 2'd2;
   localparam action_type ACT_DIV = 2'd3;

   typedef struct packed {
      logic signed [RES_W-1:0] res_re;
      logic signed [RES_W-1:0] res_im;
      logic                    div_by_zero;
   } result_type;

endpackage

>>> rtl/core/cialu_div.sv
module cialu_div #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [2*OPERAND_WIDTH-1:0] num_mag,
   input  logic [2*OPERAND_WIDTH-1:0] den,
   output logic [OPERAND_WIDTH-1:0]   quo
);

   localparam int W      = OPERAND_WIDTH;
   localparam int NMW    = 2 * W;
   localparam int QW     = W;
   localparam int STAGES = W;

   logic [NMW-1:0] rem_ff [STAGES-1];
   logic [QW-1:0]  low_ff [STAGES-1];
   logic [NMW-1:0] den_ff [STAGES-1];
   logic [QW-1:0]  quo_ff [STAGES];

   // one quotient bit per stage, msb first
   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      logic [NMW-1:0] rem_src;
      logic [NMW-1:0] den_src;
      logic [QW-1:0]  low_src;
      logic [QW-1:0]  quo_src;
      logic [NMW-1:0] trial;
      logic [NMW:0]   diff;
      logic [QW-1:0]  quo_in;

      if (j == 0) begin : g_first
         // quotient fits in QW bits, so the top bits start below den
         assign rem_src = num_mag >> QW;
         assign low_src = num_mag[QW-1:0];
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign low_src = low_ff[j-1];
         assign den_src = den_ff[j-1];
         assign quo_src = quo_ff[j-1];
      end

      assign trial  = {rem_src[NMW-2:0], low_src[QW-1]};
      assign diff   = {1'b0, trial} - {1'b0, den_src};
      assign quo_in = {quo_src[QW-2:0], ~diff[NMW]};

      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[j] <= quo_in;
         end
      end

      if (j < STAGES - 1) begin : g_carry
         logic [NMW-1:0] rem_in;
         logic [QW-1:0]  low_in;

         assign rem_in = diff[NMW] ? trial : diff[NMW-1:0];
         assign low_in = {low_src[QW-2:0], 1'b0};

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[j] <= rem_in;
               low_ff[j] <= low_in;
               den_ff[j] <= den_src;
            end
         end
      end
   end

   assign quo = quo_ff[STAGES-1];

endmodule

>>> rtl/core/complex_integer_alu_core.sv
// channel | direction | tdata (lsb first)              | tuser        | tlast
// req_    | in        | a_re, a_im, b_re, b_im         | action       | none
// rsp_    | out       | res_re, res_im, zero pad       | div_by_zero  | none
//
// one transfer per cycle in and out while req_tready and rsp_tready stay high; the pipe length
// is set mostly by the divider that resolves one quotient bit per stage
// reset clears the valid bits of every stage, the output register and the skid entry
// a stall on rsp_ freezes the pipe once the skid entry has caught an item that lands during it;
// req_tready is low only while that entry is full
module complex_integer_alu_core
   import cialu_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // a_re, a_im, b_re, b_im
   input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]     req_tdata,
   // action
   input  logic [1:0]                               req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // res_re, res_im, zero pad
   output logic [OUT_DATA_W-1:0]                    rsp_tdata,
   // div_by_zero
   output logic                                     rsp_tuser
);

   localparam int W     = OPERAND_WIDTH;
   localparam int SW    = 2 * W + 1;
   localparam int NMW   = 2 * W;
   localparam int DEPTH = W;

   logic pipe_en;

   // stage a: operand capture
   logic                valid_a_ff;
   action_type          act_a_ff;
   logic signed [W-1:0] ar_a_ff;
   logic signed [W-1:0] ai_a_ff;
   logic signed [W-1:0] br_a_ff;
   logic signed [W-1:0] bi_a_ff;

   // stage b: products and short sums
   logic                  valid_b_ff;
   action_type            act_b_ff;
   logic                  bzero_b_ff;
   logic signed [2*W-1:0] p0_b_ff;
   logic signed [2*W-1:0] p1_b_ff;
   logic signed [2*W-1:0] p2_b_ff;
   logic signed [2*W-1:0] p3_b_ff;
   logic signed [2*W-1:0] sqr_b_ff;
   logic signed [2*W-1:0] sqi_b_ff;
   logic signed [W:0]     sum_re_b_ff;
   logic signed [W:0]     sum_im_b_ff;
   logic signed [W:0]     dif_re_b_ff;
   logic signed [W:0]     dif_im_b_ff;

   // stage c: action select
   logic                 valid_c_ff;
   logic                 div_c_ff;
   logic                 zero_c_ff;
   logic signed [SW-1:0] x_re_c_ff;
   logic signed [SW-1:0] x_im_c_ff;
   logic [NMW-1:0]       den_c_ff;
   logic signed [SW-1:0] x_re_c_in;
   logic signed [SW-1:0] x_im_c_in;

   // stage d: sign and magnitude
   logic                    valid_d_ff;
   logic                    div_d_ff;
   logic                    zero_d_ff;
   logic                    neg_re_d_ff;
   logic                    neg_im_d_ff;
   logic [NMW-1:0]          mag_re_d_ff;
   logic [NMW-1:0]          mag_im_d_ff;
   logic [NMW-1:0]          den_d_ff;
   logic signed [RES_W-1:0] res_re_d_ff;
   logic signed [RES_W-1:0] res_im_d_ff;
   logic signed [SW-1:0]    abs_re_in;
   logic signed [SW-1:0]    abs_im_in;

   // side band beside the divider
   logic                    valid_s_ff [DEPTH];
   logic                    div_s_ff   [DEPTH];
   logic                    zero_s_ff  [DEPTH];
   logic                    nre_s_ff   [DEPTH];
   logic                    nim_s_ff   [DEPTH];
   logic signed [RES_W-1:0] sre_s_ff   [DEPTH];
   logic signed [RES_W-1:0] sim_s_ff   [DEPTH];

   logic [W-1:0]     q_re;
   logic [W-1:0]     q_im;
   logic [RES_W-1:0] qx_re;
   logic [RES_W-1:0] qx_im;
   logic             push;
   result_type       fin;

   // output register and skid entry
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_ff;
   result_type out_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type skid_ff;
   result_type skid_in;

   assign pipe_en    = ~skid_valid_ff;
   assign req_tready = pipe_en;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
         for (int j = 0; j < DEPTH; j++) begin
            valid_s_ff[j] <= 1'b0;
         end
      end else if (pipe_en) begin
         valid_a_ff    <= req_tvalid;
         valid_b_ff    <= valid_a_ff;
         valid_c_ff    <= valid_b_ff;
         valid_d_ff    <= valid_c_ff;
         valid_s_ff[0] <= valid_d_ff;
         for (int j = 1; j < DEPTH; j++) begin
            valid_s_ff[j] <= valid_s_ff[j-1];
         end
      end
   end

   // stage a
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         act_a_ff <= req_tuser;
         ar_a_ff  <= req_tdata[W-1:0];
         ai_a_ff  <= req_tdata[2*W-1:W];
         br_a_ff  <= req_tdata[3*W-1:2*W];
         bi_a_ff  <= req_tdata[4*W-1:3*W];
      end
   end

   // stage b
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         act_b_ff    <= act_a_ff;
         bzero_b_ff  <= (br_a_ff == '0) && (bi_a_ff == '0);
         p0_b_ff     <= ar_a_ff * br_a_ff;
         p1_b_ff     <= ai_a_ff * bi_a_ff;
         p2_b_ff     <= ar_a_ff * bi_a_ff;
         p3_b_ff     <= ai_a_ff * br_a_ff;
         sqr_b_ff    <= br_a_ff * br_a_ff;
         sqi_b_ff    <= bi_a_ff * bi_a_ff;
         sum_re_b_ff <= (W+1)'(ar_a_ff) + (W+1)'(br_a_ff);
         sum_im_b_ff <= (W+1)'(ai_a_ff) + (W+1)'(bi_a_ff);
         dif_re_b_ff <= (W+1)'(ar_a_ff) - (W+1)'(br_a_ff);
         dif_im_b_ff <= (W+1)'(ai_a_ff) - (W+1)'(bi_a_ff);
      end
   end

   // stage c
   always_comb begin
      case (act_b_ff)
         ACT_ADD: begin
            x_re_c_in = SW'(sum_re_b_ff);
            x_im_c_in = SW'(sum_im_b_ff);
         end
         ACT_SUB: begin
            x_re_c_in = SW'(dif_re_b_ff);
            x_im_c_in = SW'(dif_im_b_ff);
         end
         ACT_MUL: begin
            x_re_c_in = SW'(p0_b_ff) - SW'(p1_b_ff);
            x_im_c_in = SW'(p2_b_ff) + SW'(p3_b_ff);
         end
         ACT_DIV: begin
            // numerators of a times conj(b)
            x_re_c_in = SW'(p0_b_ff) + SW'(p1_b_ff);
            x_im_c_in = SW'(p3_b_ff) - SW'(p2_b_ff);
         end
         default: begin
            x_re_c_in = '0;
            x_im_c_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         div_c_ff  <= (act_b_ff == ACT_DIV);
         zero_c_ff <= (act_b_ff == ACT_DIV) && bzero_b_ff;
         x_re_c_ff <= x_re_c_in;
         x_im_c_ff <= x_im_c_in;
         den_c_ff  <= $unsigned(sqr_b_ff) + $unsigned(sqi_b_ff);
      end
   end

   // stage d
   assign abs_re_in = x_re_c_ff[SW-1] ? -x_re_c_ff : x_re_c_ff;
   assign abs_im_in = x_im_c_ff[SW-1] ? -x_im_c_ff : x_im_c_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         div_d_ff    <= div_c_ff;
         zero_d_ff   <= zero_c_ff;
         neg_re_d_ff <= x_re_c_ff[SW-1];
         neg_im_d_ff <= x_im_c_ff[SW-1];
         mag_re_d_ff <= abs_re_in[NMW-1:0];
         mag_im_d_ff <= abs_im_in[NMW-1:0];
         den_d_ff    <= den_c_ff;
         res_re_d_ff <= RES_W'(x_re_c_ff);
         res_im_d_ff <= RES_W'(x_im_c_ff);
      end
   end

   // divider lanes
   cialu_div #(
      .OPERAND_WIDTH (W)
   ) u_div_re (
      .clock   (clock),
      .enable  (pipe_en),
      .num_mag (mag_re_d_ff),
      .den     (den_d_ff),
      .quo     (q_re)
   );

   cialu_div #(
      .OPERAND_WIDTH (W)
   ) u_div_im (
      .clock   (clock),
      .enable  (pipe_en),
      .num_mag (mag_im_d_ff),
      .den     (den_d_ff),
      .quo     (q_im)
   );

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         div_s_ff[0]  <= div_d_ff;
         zero_s_ff[0] <= zero_d_ff;
         nre_s_ff[0]  <= neg_re_d_ff;
         nim_s_ff[0]  <= neg_im_d_ff;
         sre_s_ff[0]  <= res_re_d_ff;
         sim_s_ff[0]  <= res_im_d_ff;
         for (int j = 1; j < DEPTH; j++) begin
            div_s_ff[j]  <= div_s_ff[j-1];
            zero_s_ff[j] <= zero_s_ff[j-1];
            nre_s_ff[j]  <= nre_s_ff[j-1];
            nim_s_ff[j]  <= nim_s_ff[j-1];
            sre_s_ff[j]  <= sre_s_ff[j-1];
            sim_s_ff[j]  <= sim_s_ff[j-1];
         end
      end
   end

   // final select
   assign qx_re = {{(RES_W-W){1'b0}}, q_re};
   assign qx_im = {{(RES_W-W){1'b0}}, q_im};

   always_comb begin
      if (!div_s_ff[DEPTH-1]) begin
         fin.res_re      = sre_s_ff[DEPTH-1];
         fin.res_im      = sim_s_ff[DEPTH-1];
         fin.div_by_zero = 1'b0;
      end else if (zero_s_ff[DEPTH-1]) begin
         fin.res_re      = '0;
         fin.res_im      = '0;
         fin.div_by_zero = 1'b1;
      end else begin
         fin.res_re      = nre_s_ff[DEPTH-1] ? -$signed(qx_re) : $signed(qx_re);
         fin.res_im      = nim_s_ff[DEPTH-1] ? -$signed(qx_im) : $signed(qx_im);
         fin.div_by_zero = 1'b0;
      end
   end

   assign push = pipe_en && valid_s_ff[DEPTH-1];

   // output register with one skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_in       = fin;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(OUT_DATA_W-2*RES_W){1'b0}}, out_ff.res_im, out_ff.res_re};
   assign rsp_tuser  = out_ff.div_by_zero;

`ifndef SYNTHESIS
   // skid entry only fills behind a held output
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full while output register empty");

   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready))
      else $error("skid entry filled without an output stall");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.div_by_zero) |-> (out_ff.res_re == '0 && out_ff.res_im == '0))
      else $error("divide by zero result not cleared");

   assert property (@(posedge clock) disable iff (reset)
      (valid_s_ff[DEPTH-1] && zero_s_ff[DEPTH-1]) |-> div_s_ff[DEPTH-1])
      else $error("zero divisor flag on a non divide item");
`endif

endmodule
